/* hdl/urde_pkg.sv */
// Shared types, constants and the CRC8 byte update for the register datagram engine.
// No dependencies; imported by every module of the block.
package urde_pkg;

  localparam logic [7:0]  CRC_POLY      = 8'h07;
  localparam logic        WRITE_BIT     = 1'b1;
  localparam logic [31:0] FAIL_DATA     = 32'hFFFF_FFFF;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned REPLY_LAST    = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_TAG    = 2'd2;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_RX      = 2'd2,
    KIND_TIMEOUT = 2'd3
  } in_kind_e;

  typedef enum logic {
    OUT_TX   = 1'b0,
    OUT_DONE = 1'b1
  } out_kind_e;

  typedef enum logic [1:0] {
    ST_SUCCESS  = 2'd0,
    ST_NO_REPLY = 2'd1,
    ST_FORMAT   = 2'd2,
    ST_BAD_CRC  = 2'd3
  } read_status_e;

  typedef enum logic [1:0] {
    JOB_READ  = 2'd0,
    JOB_WRITE = 2'd1,
    JOB_DONE  = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e    kind;
    logic [6:0]   reg_addr;
    logic [31:0]  data;
    read_status_e status;
  } job_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [7:0] sync_pattern;
    logic [7:0] master_tag;
  } cfg_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[7] ^ data[k]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/urde_front.sv */
// Front end: accepts requests and received bytes, runs the reply checker, queues jobs.
// Depends on urde_pkg.
module urde_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  urde_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    kind_i,
  input  logic [6:0]    reg_address_i,
  input  logic [31:0]   write_data_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output urde_pkg::job_t q_job_o
);
  import urde_pkg::*;

  logic        awaiting_q, awaiting_d;
  logic [6:0]  exp_reg_q, exp_reg_d;
  logic [3:0]  count_q, count_d;
  logic [7:0]  crc_q, crc_d;
  logic [31:0] data_q, data_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic        accept;
  in_kind_e    kind;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign kind       = in_kind_e'(kind_i);

  always_comb begin
    awaiting_d = awaiting_q;
    exp_reg_d  = exp_reg_q;
    count_d    = count_q;
    crc_d      = crc_q;
    data_d     = data_q;
    hdr_ok_d   = hdr_ok_q;
    q_push_o   = 1'b0;
    q_job_o.kind     = JOB_READ;
    q_job_o.reg_addr = reg_address_i;
    q_job_o.data     = write_data_i;
    q_job_o.status   = ST_SUCCESS;
    if (accept) begin
      unique case (kind)
        KIND_READ: begin
          q_push_o   = 1'b1;
          awaiting_d = 1'b1;
          exp_reg_d  = reg_address_i;
          count_d    = '0;
          crc_d      = '0;
          data_d     = '0;
          hdr_ok_d   = 1'b1;
        end
        KIND_WRITE: begin
          q_push_o     = 1'b1;
          q_job_o.kind = JOB_WRITE;
        end
        KIND_TIMEOUT: begin
          if (awaiting_q) begin
            q_push_o       = 1'b1;
            q_job_o.kind   = JOB_DONE;
            q_job_o.data   = FAIL_DATA;
            q_job_o.status = ST_NO_REPLY;
            awaiting_d     = 1'b0;
            count_d        = '0;
          end
        end
        KIND_RX: begin
          if (awaiting_q) begin
            if (count_q < 4'(REPLY_LAST)) begin
              if (count_q == 4'd0 && rx_byte_i != cfg_i.sync_pattern) hdr_ok_d = 1'b0;
              if (count_q == 4'd1 && rx_byte_i != cfg_i.master_tag) hdr_ok_d = 1'b0;
              if (count_q == 4'd2 && rx_byte_i != {1'b0, exp_reg_q}) hdr_ok_d = 1'b0;
              if (count_q >= 4'd3) data_d = {data_q[23:0], rx_byte_i};
              crc_d   = crc_feed(crc_q, rx_byte_i);
              count_d = count_q + 4'd1;
            end else begin
              q_push_o     = 1'b1;
              q_job_o.kind = JOB_DONE;
              awaiting_d   = 1'b0;
              count_d      = '0;
              if (!hdr_ok_q) begin
                q_job_o.data   = FAIL_DATA;
                q_job_o.status = ST_FORMAT;
              end else if (rx_byte_i != crc_q) begin
                q_job_o.data   = FAIL_DATA;
                q_job_o.status = ST_BAD_CRC;
              end else begin
                q_job_o.data   = data_q;
                q_job_o.status = ST_SUCCESS;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      exp_reg_q  <= '0;
      count_q    <= '0;
      crc_q      <= '0;
      data_q     <= '0;
      hdr_ok_q   <= 1'b1;
    end else begin
      awaiting_q <= awaiting_d;
      exp_reg_q  <= exp_reg_d;
      count_q    <= count_d;
      crc_q      <= crc_d;
      data_q     <= data_d;
      hdr_ok_q   <= hdr_ok_d;
    end
  end

endmodule

/* hdl/urde_fifo.sv */
// Job queue between front and back ends; power-of-two depth.
// Depends on urde_pkg for the job type.
module urde_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  urde_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           avail_o,
  output urde_pkg::job_t head_o
);
  import urde_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t        mem_q [DEPTH];
  logic [AW:0] wr_q, rd_q;

  assign avail_o = (wr_q != rd_q);
  assign full_o  = (wr_q[AW-1:0] == rd_q[AW-1:0]) && (wr_q[AW] != rd_q[AW]);
  assign head_o  = mem_q[rd_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q[AW-1:0]] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 1'b1;
      if (pop_i && avail_o)  rd_q <= rd_q + 1'b1;
    end
  end

endmodule

/* hdl/urde_back.sv */
// Back end: turns queued jobs into datagram bytes with CRC8, or read completions.
// Depends on urde_pkg; holds the output register.
module urde_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  urde_pkg::cfg_t cfg_i,
  input  logic           q_avail_i,
  input  urde_pkg::job_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           out_kind_o,
  output logic [7:0]     tx_byte_o,
  output logic           tx_last_o,
  output logic [31:0]    read_data_o,
  output logic [1:0]     read_status_o
);
  import urde_pkg::*;

  job_t       job_q;
  logic       job_valid_q;
  logic [2:0] idx_q;
  logic [7:0] crc_q;

  logic        out_valid_q;
  out_kind_e   out_kind_q;
  logic [7:0]  tx_byte_q;
  logic        tx_last_q;
  logic [31:0] read_data_q;
  logic [1:0]  read_status_q;

  logic       slot_free, emit, is_done, at_crc, finish;
  logic [2:0] last_idx;
  logic [7:0] body_byte, cur_byte;

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = job_valid_q && slot_free;
  assign is_done   = (job_q.kind == JOB_DONE);
  assign last_idx  = (job_q.kind == JOB_WRITE) ? 3'd7 : 3'd3;
  assign at_crc    = (idx_q == last_idx);
  assign finish    = emit && (is_done || at_crc);
  assign q_pop_o   = q_avail_i && (!job_valid_q || finish);

  always_comb begin
    unique case (idx_q)
      3'd0:    body_byte = cfg_i.sync_pattern;
      3'd1:    body_byte = cfg_i.slave_address;
      3'd2:    body_byte = {(job_q.kind == JOB_WRITE) ? WRITE_BIT : 1'b0, job_q.reg_addr};
      3'd3:    body_byte = job_q.data[31:24];
      3'd4:    body_byte = job_q.data[23:16];
      3'd5:    body_byte = job_q.data[15:8];
      3'd6:    body_byte = job_q.data[7:0];
      default: body_byte = 8'h00;
    endcase
    cur_byte = at_crc ? crc_q : body_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      crc_q       <= '0;
    end else if (q_pop_o) begin
      job_valid_q <= 1'b1;
      idx_q       <= '0;
      crc_q       <= '0;
    end else if (finish) begin
      job_valid_q <= 1'b0;
    end else if (emit) begin
      idx_q <= idx_q + 3'd1;
      crc_q <= crc_feed(crc_q, cur_byte);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= q_head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (is_done) begin
        out_kind_q    <= OUT_DONE;
        tx_byte_q     <= '0;
        tx_last_q     <= 1'b0;
        read_data_q   <= job_q.data;
        read_status_q <= job_q.status;
      end else begin
        out_kind_q    <= OUT_TX;
        tx_byte_q     <= cur_byte;
        tx_last_q     <= at_crc;
        read_data_q   <= '0;
        read_status_q <= ST_SUCCESS;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign tx_byte_o     = tx_byte_q;
  assign tx_last_o     = tx_last_q;
  assign read_data_o   = read_data_q;
  assign read_status_o = read_status_q;

endmodule

/* hdl/uart_register_datagram_engine_core.sv */
// Top level of the register datagram engine: configuration registers, front, queue, back.
// Depends on urde_pkg, urde_front, urde_fifo and urde_back.
//
// Input channel (in_valid_i/in_ready_o) carries read requests, write requests,
// received link bytes and reply timeouts. One item transfers per cycle while the
// job queue has room; received bytes and timeouts that raise no result take no
// queue entry but still need in_ready_o.
// Output channel (out_valid_o/out_ready_i) carries transmit bytes and read
// completions from a single output register.
// A read request gives 4 bytes, a write request 8; a reply's eighth byte, or a
// timeout while a reply is awaited, gives one completion. All pass the job queue,
// the back end's job register and the output register. Unstalled, output is one
// result per cycle, with no gap between queued datagrams, and the CRC8 is built one
// byte a cycle. When the receiver stalls, the output register holds, the back end
// stops, and the queue fills; in_ready_o falls once QUEUE_DEPTH jobs are waiting.
// Reset clears the reply checker, the queue and the output valid and loads the
// register defaults: slave address 0, sync pattern 5, master tag 255.
module uart_register_datagram_engine_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [6:0]  reg_address_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic [31:0] read_data_o,
  output logic [1:0]  read_status_o
);
  import urde_pkg::*;

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_avail;
  job_t q_job, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address <= 8'd0;
      cfg_q.sync_pattern  <= 8'd5;
      cfg_q.master_tag    <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SLAVE_ADDRESS: cfg_q.slave_address <= cfg_data_i;
        CFG_SYNC_PATTERN:  cfg_q.sync_pattern  <= cfg_data_i;
        CFG_MASTER_TAG:    cfg_q.master_tag    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  urde_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .reg_address_i (reg_address_i),
    .write_data_i  (write_data_i),
    .rx_byte_i     (rx_byte_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (q_job)
  );

  urde_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .avail_o    (q_avail),
    .head_o     (q_head)
  );

  urde_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_avail_i     (q_avail),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_kind_o    (out_kind_o),
    .tx_byte_o     (tx_byte_o),
    .tx_last_o     (tx_last_o),
    .read_data_o   (read_data_o),
    .read_status_o (read_status_o)
  );

endmodule

/* hdl/urde_checker.sv */
// Port-level checks of the register datagram engine, bound to its top level.
// Depends on urde_pkg and uart_register_datagram_engine_core.
module urde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        out_kind_o,
  input logic [7:0]  tx_byte_o,
  input logic        tx_last_o,
  input logic [31:0] read_data_o,
  input logic [1:0]  read_status_o
);
  import urde_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_kind_o) &&
      $stable(tx_byte_o) && $stable(tx_last_o) && $stable(read_data_o) &&
      $stable(read_status_o))
    else $error("stalled result changed");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == OUT_TX |-> read_data_o == '0 && read_status_o == ST_SUCCESS)
    else $error("transmit byte carries completion fields");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == OUT_DONE |-> tx_byte_o == '0 && !tx_last_o)
    else $error("completion carries transmit fields");

  a_fail_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == OUT_DONE && read_status_o != ST_SUCCESS
      |-> read_data_o == FAIL_DATA)
    else $error("failed read without all-ones data");

endmodule

bind uart_register_datagram_engine_core urde_checker u_checker (.*);
